/* sv/shunt_pkg.sv */
// ----------------------------------------------------------------------------
// shunt_pkg: shared types and constants of the infix to postfix unit
// Token and operator codes, stack entry encoding, sequencer states and the
// packed word types of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package shunt_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int VALUE_W         = 32;
  localparam int FUNC_W          = 3;
  localparam int OP_W            = 3;
  localparam int KIND_W          = 2;
  localparam int ENTRY_W         = 3;

  // token kinds on the input side
  localparam logic [FUNC_W-1:0] FN_OPERAND  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_OPERATOR = 3'd1;
  localparam logic [FUNC_W-1:0] FN_OPEN     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CLOSE    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_END      = 3'd4;

  // operator codes, precedence is code >> 1
  localparam logic [OP_W-1:0] OP_MINUS = 3'd0;
  localparam logic [OP_W-1:0] OP_PLUS  = 3'd1;
  localparam logic [OP_W-1:0] OP_DIV   = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL   = 3'd3;
  localparam logic [OP_W-1:0] OP_POW   = 3'd4;

  // stack entry holding an open parenthesis
  localparam logic [ENTRY_W-1:0] ENTRY_PAREN = 3'd5;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_OPERAND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OPERATOR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_TEST,
    ST_PUSH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [OP_W-1:0]    op_code;
    logic [VALUE_W-1:0] operand_value;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  out_kind;
    logic [OP_W-1:0]    out_op;
    logic [VALUE_W-1:0] out_value;
    logic               last;
    logic               error;
  } result_t;

endpackage

`default_nettype wire

/* sv/shunt_ram.sv */
// ----------------------------------------------------------------------------
// shunt_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module shunt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/shunt_cmp.sv */
// ----------------------------------------------------------------------------
// shunt_cmp: pop decision unit
// Decides whether the stack top leaves the stack for the token being handled.
// ----------------------------------------------------------------------------
`default_nettype none

module shunt_cmp (
  input  wire logic [shunt_pkg::FUNC_W-1:0]  func,
  input  wire logic [shunt_pkg::ENTRY_W-1:0] top_entry,
  input  wire logic [shunt_pkg::OP_W-1:0]    op_code,
  output logic                               pop
);

  logic [1:0] prec_top;
  logic [1:0] prec_in;
  logic       top_paren;

  assign prec_top  = top_entry[2:1];
  assign prec_in   = op_code[2:1];
  assign top_paren = (top_entry == shunt_pkg::ENTRY_PAREN);

  always_comb begin
    priority if (func == shunt_pkg::FN_END) begin
      pop = 1'b1;
    end else if (func == shunt_pkg::FN_CLOSE) begin
      pop = !top_paren;
    end else if (func == shunt_pkg::FN_OPERATOR) begin
      // power is right-associative, so equal precedence does not pop it
      pop = !top_paren && ((prec_top > prec_in) ||
            ((prec_top == prec_in) && (op_code != shunt_pkg::OP_POW)));
    end else begin
      pop = 1'b0;
    end
  end

endmodule

`default_nettype wire

/* sv/shunting_yard_infix_to_postfix_unit.sv */
// ----------------------------------------------------------------------------
// shunting_yard_infix_to_postfix_unit: infix to postfix token converter
// Operators and open parentheses wait on a RAM stack; a small sequencer
// pops them one at a time through a shared precedence compare.
// ----------------------------------------------------------------------------
//
//   channel   signals                          word
//   input     item_valid / item_ready          item   (func, op_code, value)
//   output    result_valid / result_ready      result (kind, op, value, last, error)
//
// An accepted operand goes from START into the hold register and from FINISH
// into the output register. Every stack pop reads the top from the stack RAM
// in READ, then compares it in TEST; the registered RAM read sets this split.
// One popped word is held back until the next decision, so last is known.
// Synchronous reset empties the stack at once; no clearing pass is needed.
// A stalled output holds the sequencer; no item is taken until one is done.
//
`default_nettype none

module shunting_yard_infix_to_postfix_unit #(
  parameter int STACK_DEPTH = shunt_pkg::STACK_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire shunt_pkg::item_t  item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output shunt_pkg::result_t     result
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  shunt_pkg::state_t state, state_next;
  shunt_pkg::item_t  cur;

  logic [CW-1:0] cnt;
  logic [CW-1:0] pcnt;
  logic          err;

  logic                             hold_v;
  logic [shunt_pkg::KIND_W-1:0]     hold_kind;
  logic [shunt_pkg::OP_W-1:0]       hold_op;
  logic [shunt_pkg::VALUE_W-1:0]    hold_val;

  logic [CW-1:0]                 cnt_dec;
  logic [shunt_pkg::ENTRY_W-1:0] rdata;
  logic [shunt_pkg::ENTRY_W-1:0] wdata;
  logic                          pop;
  logic                          top_paren;
  logic                          emit;
  logic                          free;
  logic                          bad_item;

  // control from the output decode
  logic we;
  logic send;
  logic send_last;
  logic load_operand;
  logic load_popped;
  logic clear_hold;
  logic cnt_up;
  logic cnt_down;
  logic pcnt_up;
  logic pcnt_down;
  logic err_init;
  logic err_full;

  assign cnt_dec   = cnt - 1'b1;
  assign top_paren = (rdata == shunt_pkg::ENTRY_PAREN);
  assign emit      = pop && !top_paren;
  assign free      = !result_valid || result_ready;
  assign wdata     = (cur.func == shunt_pkg::FN_OPEN) ? shunt_pkg::ENTRY_PAREN
                                                      : cur.op_code;
  assign bad_item  = (cur.func > shunt_pkg::FN_END) ||
                     ((cur.func == shunt_pkg::FN_OPERATOR) &&
                      (cur.op_code > shunt_pkg::OP_POW));
  assign item_ready = (state == shunt_pkg::ST_IDLE);

  shunt_ram #(
    .WIDTH (shunt_pkg::ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (cnt[AW-1:0]),
    .wdata (wdata),
    .raddr (cnt_dec[AW-1:0]),
    .rdata (rdata)
  );

  shunt_cmp u_cmp (
    .func      (cur.func),
    .top_entry (rdata),
    .op_code   (cur.op_code),
    .pop       (pop)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      shunt_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = shunt_pkg::ST_START;
        end
      end
      shunt_pkg::ST_START: begin
        priority if (bad_item) begin
          state_next = shunt_pkg::ST_IDLE;
        end else if (cur.func == shunt_pkg::FN_OPERAND) begin
          state_next = shunt_pkg::ST_FINISH;
        end else if (cur.func == shunt_pkg::FN_OPEN) begin
          state_next = shunt_pkg::ST_PUSH;
        end else if (cnt == '0) begin
          state_next = (cur.func == shunt_pkg::FN_OPERATOR) ? shunt_pkg::ST_PUSH
                                                             : shunt_pkg::ST_FINISH;
        end else begin
          state_next = shunt_pkg::ST_READ;
        end
      end
      shunt_pkg::ST_READ: begin
        state_next = shunt_pkg::ST_TEST;
      end
      shunt_pkg::ST_TEST: begin
        priority if (pop) begin
          if (!(emit && hold_v && !free)) begin
            priority if (cnt_dec != '0) begin
              state_next = shunt_pkg::ST_READ;
            end else if (cur.func == shunt_pkg::FN_OPERATOR) begin
              state_next = shunt_pkg::ST_PUSH;
            end else begin
              state_next = shunt_pkg::ST_FINISH;
            end
          end
        end else if (cur.func == shunt_pkg::FN_OPERATOR) begin
          state_next = shunt_pkg::ST_PUSH;
        end else begin
          state_next = shunt_pkg::ST_FINISH;
        end
      end
      shunt_pkg::ST_PUSH: begin
        state_next = shunt_pkg::ST_FINISH;
      end
      shunt_pkg::ST_FINISH: begin
        if (!((hold_v || err) && !free)) begin
          state_next = shunt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = shunt_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath control
  always_comb begin
    we           = 1'b0;
    send         = 1'b0;
    send_last    = 1'b0;
    load_operand = 1'b0;
    load_popped  = 1'b0;
    clear_hold   = 1'b0;
    cnt_up       = 1'b0;
    cnt_down     = 1'b0;
    pcnt_up      = 1'b0;
    pcnt_down    = 1'b0;
    err_init     = 1'b0;
    err_full     = 1'b0;
    unique case (state)
      shunt_pkg::ST_START: begin
        load_operand = (cur.func == shunt_pkg::FN_OPERAND);
        // paren mismatches are known up front from the paren count
        err_init = ((cur.func == shunt_pkg::FN_CLOSE) && (pcnt == '0)) ||
                   ((cur.func == shunt_pkg::FN_END) && (pcnt != '0));
      end
      shunt_pkg::ST_TEST: begin
        if (pop) begin
          if (!(emit && hold_v && !free)) begin
            cnt_down    = 1'b1;
            pcnt_down   = top_paren;
            load_popped = emit;
            send        = emit && hold_v;
          end
        end else if (cur.func == shunt_pkg::FN_CLOSE) begin
          // matching open paren found, drop it
          cnt_down  = 1'b1;
          pcnt_down = 1'b1;
        end
      end
      shunt_pkg::ST_PUSH: begin
        if (cnt != FULL) begin
          we      = 1'b1;
          cnt_up  = 1'b1;
          pcnt_up = (cur.func == shunt_pkg::FN_OPEN);
        end else begin
          err_full = 1'b1;
        end
      end
      shunt_pkg::ST_FINISH: begin
        if ((hold_v || err) && free) begin
          send       = 1'b1;
          send_last  = 1'b1;
          clear_hold = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= shunt_pkg::ST_IDLE;
      cnt          <= '0;
      pcnt         <= '0;
      err          <= 1'b0;
      hold_v       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cnt_up) begin
        cnt <= cnt + 1'b1;
      end else if (cnt_down) begin
        cnt <= cnt_dec;
      end

      if (pcnt_up) begin
        pcnt <= pcnt + 1'b1;
      end else if (pcnt_down) begin
        pcnt <= pcnt - 1'b1;
      end

      if (state == shunt_pkg::ST_START) begin
        err <= err_init;
      end else if (err_full) begin
        err <= 1'b1;
      end

      if (load_operand || load_popped) begin
        hold_v <= 1'b1;
      end else if (clear_hold) begin
        hold_v <= 1'b0;
      end

      if (send) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      cur <= item;
    end

    if (load_operand) begin
      hold_kind <= shunt_pkg::KIND_OPERAND;
      hold_op   <= '0;
      hold_val  <= cur.operand_value;
    end else if (load_popped) begin
      hold_kind <= shunt_pkg::KIND_OPERATOR;
      hold_op   <= rdata;
      hold_val  <= '0;
    end

    if (send) begin
      // error only word when nothing is held
      result.out_kind  <= hold_v ? hold_kind : shunt_pkg::KIND_NONE;
      result.out_op    <= hold_v ? hold_op : '0;
      result.out_value <= hold_v ? hold_val : '0;
      result.last      <= send_last;
      result.error     <= err;
    end
  end

endmodule

`default_nettype wire

/* verif/shunting_yard_infix_to_postfix_unit_tb.sv */
// ----------------------------------------------------------------------------
// shunting_yard_infix_to_postfix_unit_tb: self-checking bench of the converter
// Drives infix tokens into the unit and checks every postfix word it emits.
// A behavioral operator stack alongside the DUT predicts each token's words.
// Directed tests cover precedence, associativity, parenthesis errors, a full
// stack and unknown codes. Random expressions with some noise and broken
// nesting follow, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module shunting_yard_infix_to_postfix_unit_tb;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 100;
  localparam int DRAIN_CYCLES = 64;

  typedef logic [shunt_pkg::FUNC_W-1:0] func_code_t;
  typedef logic [shunt_pkg::OP_W-1:0]   op_code_t;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  shunt_pkg::item_t   item;
  logic               result_valid;
  logic               result_ready;
  shunt_pkg::result_t result;

  shunting_yard_infix_to_postfix_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // behavioral operator stack
  logic [shunt_pkg::ENTRY_W-1:0] opstack_mdl [shunt_pkg::STACK_DEPTH_DEF];
  int                            opstack_fill;

  shunt_pkg::result_t postfix_q [$];
  bit      idle_en        = 1'b1;
  int      tokens_used    = 0;
  int      tokens_ignored = 0;
  int      words_checked  = 0;
  int      error_words    = 0;
  int      mismatches     = 0;
  int      cycle_count    = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic shunt_pkg::item_t make_token(func_code_t func, op_code_t op,
                                                  logic [shunt_pkg::VALUE_W-1:0] value);
    shunt_pkg::item_t t;
    t.func          = func;
    t.op_code       = op;
    t.operand_value = value;
    return t;
  endfunction

  function automatic shunt_pkg::result_t make_word(logic [shunt_pkg::KIND_W-1:0] kind,
                                                   op_code_t op,
                                                   logic [shunt_pkg::VALUE_W-1:0] value);
    shunt_pkg::result_t w;
    w.out_kind  = kind;
    w.out_op    = op;
    w.out_value = value;
    w.last      = 1'b0;
    w.error     = 1'b0;
    return w;
  endfunction

  // stacked entry leaves before the incoming operator is pushed
  function automatic bit outranks(logic [shunt_pkg::ENTRY_W-1:0] top, op_code_t incoming);
    if (top == shunt_pkg::ENTRY_PAREN) return 1'b0;
    return (top >> 1) > (incoming >> 1) ||
           ((top >> 1) == (incoming >> 1) && incoming != shunt_pkg::OP_POW);
  endfunction

  // works out the postfix words released by one accepted token
  function automatic void convert_token(shunt_pkg::item_t tok);
    shunt_pkg::result_t words [$];
    bit                 err;
    err = 1'b0;
    case (tok.func)
      shunt_pkg::FN_OPERAND: begin
        words.insert(words.size(),
                     make_word(shunt_pkg::KIND_OPERAND, '0, tok.operand_value));
      end
      shunt_pkg::FN_OPERATOR: begin
        if (tok.op_code > shunt_pkg::OP_POW) begin
          tokens_ignored++;
          return;
        end
        while (opstack_fill > 0 && outranks(opstack_mdl[opstack_fill-1], tok.op_code)) begin
          words.insert(words.size(), make_word(shunt_pkg::KIND_OPERATOR,
                                               opstack_mdl[opstack_fill-1], '0));
          opstack_fill--;
        end
        if (opstack_fill < shunt_pkg::STACK_DEPTH_DEF) begin
          opstack_mdl[opstack_fill] = tok.op_code;
          opstack_fill++;
        end else begin
          err = 1'b1;
        end
      end
      shunt_pkg::FN_OPEN: begin
        if (opstack_fill < shunt_pkg::STACK_DEPTH_DEF) begin
          opstack_mdl[opstack_fill] = shunt_pkg::ENTRY_PAREN;
          opstack_fill++;
        end else begin
          err = 1'b1;
        end
      end
      shunt_pkg::FN_CLOSE: begin
        while (opstack_fill > 0 && opstack_mdl[opstack_fill-1] != shunt_pkg::ENTRY_PAREN) begin
          words.insert(words.size(), make_word(shunt_pkg::KIND_OPERATOR,
                                               opstack_mdl[opstack_fill-1], '0));
          opstack_fill--;
        end
        if (opstack_fill > 0) opstack_fill--;
        else err = 1'b1;
      end
      shunt_pkg::FN_END: begin
        while (opstack_fill > 0) begin
          if (opstack_mdl[opstack_fill-1] == shunt_pkg::ENTRY_PAREN) err = 1'b1;
          else words.insert(words.size(), make_word(shunt_pkg::KIND_OPERATOR,
                                                    opstack_mdl[opstack_fill-1], '0));
          opstack_fill--;
        end
      end
      default: begin
        tokens_ignored++;
        return;
      end
    endcase
    tokens_used++;
    if (err && words.size() == 0) begin
      words.insert(0, make_word(shunt_pkg::KIND_NONE, '0, '0));
    end
    foreach (words[k]) begin
      words[k].error = err;
      words[k].last  = (k == words.size() - 1);
      postfix_q.insert(postfix_q.size(), words[k]);
    end
  endfunction

  // valid stays high across back-to-back words; it only drops for an idle burst
  task automatic send_token(shunt_pkg::item_t tok);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      item_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    item       = tok;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    convert_token(tok);
  endtask

  task automatic send_operand(logic [shunt_pkg::VALUE_W-1:0] value);
    send_token(make_token(shunt_pkg::FN_OPERAND, '0, value));
  endtask

  task automatic send_operator(op_code_t op);
    send_token(make_token(shunt_pkg::FN_OPERATOR, op, $urandom));
  endtask

  task automatic send_simple(func_code_t func);
    send_token(make_token(func, op_code_t'($urandom_range(0, 7)), $urandom));
  endtask

  function automatic logic [shunt_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // ---- receiver side ------------------------------------------------------

  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 3) == 0) begin
        result_ready = 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk);
      end else begin
        result_ready = 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [shunt_pkg::VALUE_W-1:0] want,
                                      logic [shunt_pkg::VALUE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    shunt_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (postfix_q.size() == 0) begin
        $error("unexpected word: kind %0d op %0d value %0h", result.out_kind, result.out_op,
               result.out_value);
        mismatches++;
      end else begin
        want = postfix_q.pop_front();
        check_field("out_kind", want.out_kind, result.out_kind);
        check_field("out_op", want.out_op, result.out_op);
        check_field("out_value", want.out_value, result.out_value);
        check_field("last", want.last, result.last);
        check_field("error", want.error, result.error);
        words_checked++;
        if (want.error) error_words++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               postfix_q.size());
      $display("shunting_yard_infix_to_postfix_unit_tb failed");
      $finish;
    end
  end

  // ---- tests --------------------------------------------------------------

  // left associativity within a level, right associativity of power
  task automatic test_precedence();
    send_operand('0);
    send_operator(shunt_pkg::OP_MINUS);
    send_operand('1);
    send_operator(shunt_pkg::OP_PLUS);
    send_operand(32'h8000_0001);
    send_operator(shunt_pkg::OP_DIV);
    send_operand(32'h7fff_fffe);
    send_operator(shunt_pkg::OP_MUL);
    send_operand(32'h0000_0005);
    send_operator(shunt_pkg::OP_POW);
    send_operand(32'h0000_0002);
    send_operator(shunt_pkg::OP_POW);
    send_operand(32'h0000_0003);
    send_simple(shunt_pkg::FN_END);
  endtask

  task automatic test_unknown_codes();
    send_token(make_token(3'd5, shunt_pkg::OP_PLUS, $urandom));
    send_token(make_token(3'd6, 3'd6, $urandom));
    send_token(make_token(3'd7, 3'd7, '1));
    send_token(make_token(shunt_pkg::FN_OPERATOR, 3'd5, $urandom));
    send_token(make_token(shunt_pkg::FN_OPERATOR, 3'd7, '0));
  endtask

  task automatic test_paren_errors();
    send_simple(shunt_pkg::FN_OPEN);
    send_simple(shunt_pkg::FN_CLOSE);
    // close with nothing open
    send_simple(shunt_pkg::FN_CLOSE);
    send_operand($urandom);
    send_operator(shunt_pkg::OP_PLUS);
    send_simple(shunt_pkg::FN_CLOSE);
    // unmatched opens at the end still flush operators
    send_simple(shunt_pkg::FN_OPEN);
    send_simple(shunt_pkg::FN_OPEN);
    send_operator(shunt_pkg::OP_MINUS);
    send_simple(shunt_pkg::FN_END);
    send_simple(shunt_pkg::FN_END);
  endtask

  // fills the stack with power, then overflows it and has one minus pop it all
  task automatic test_stack_full();
    repeat (shunt_pkg::STACK_DEPTH_DEF) send_operator(shunt_pkg::OP_POW);
    send_operator(shunt_pkg::OP_POW);
    send_simple(shunt_pkg::FN_OPEN);
    send_operator(shunt_pkg::OP_MINUS);
    send_simple(shunt_pkg::FN_END);
  endtask

  task automatic send_expression(bit broken);
    int terms;
    int opens;
    terms = $urandom_range(1, 6);
    opens = 0;
    for (int k = 0; k < terms; k++) begin
      while (opens < 4 && $urandom_range(0, 3) == 0) begin
        send_simple(shunt_pkg::FN_OPEN);
        opens++;
      end
      send_operand(pick_value());
      while (opens > 0 && $urandom_range(0, 2) == 0) begin
        send_simple(shunt_pkg::FN_CLOSE);
        opens--;
      end
      if (k != terms - 1) send_operator(op_code_t'($urandom_range(0, 4)));
    end
    if (broken && $urandom_range(0, 1) == 0) begin
      send_simple(shunt_pkg::FN_OPEN);
    end else begin
      repeat (opens) send_simple(shunt_pkg::FN_CLOSE);
      if (broken) send_simple(shunt_pkg::FN_CLOSE);
    end
    send_simple(shunt_pkg::FN_END);
  endtask

  task automatic test_random_expressions();
    int goal;
    int pick;
    goal = tokens_used + RANDOM_ITEMS;
    while (tokens_used < goal) begin
      if (tokens_used > goal - 40) idle_en = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_expression(1'b0);
      end else if (pick == 7) begin
        send_expression(1'b1);
      end else begin
        repeat ($urandom_range(1, 3))
          send_token(make_token(func_code_t'($urandom_range(0, 7)),
                                op_code_t'($urandom_range(0, 7)), $urandom));
      end
    end
    send_simple(shunt_pkg::FN_END);
  endtask

  initial begin
    opstack_fill = 0;
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    test_precedence();
    test_unknown_codes();
    test_paren_errors();
    test_stack_full();
    test_random_expressions();

    @(negedge clk);
    item_valid = 1'b0;
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d tokens converted, %0d unknown codes dropped", tokens_used, tokens_ignored);
    $display("%0d postfix words checked, %0d of them flagged as errors", words_checked,
             error_words);
    if (mismatches == 0) begin
      $display("shunting_yard_infix_to_postfix_unit_tb passed");
    end else begin
      $display("shunting_yard_infix_to_postfix_unit_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
sv/shunt_pkg.sv
sv/shunt_ram.sv
sv/shunt_cmp.sv
sv/shunting_yard_infix_to_postfix_unit.sv
verif/shunting_yard_infix_to_postfix_unit_tb.sv
